@@ hw/rtl/slpa_pkg.sv @@
// ----------------------------------------------------------------------------
// slpa_pkg: shared types and constants for the short/long press action block
// Event codes, action codes, target kinds, register indexes and the item and
// result structures passed between the pipeline stages.
// ----------------------------------------------------------------------------
package slpa_pkg;

   localparam int TIMER_BITS_DEF = 16;

   localparam int OP_W     = 2;
   localparam int ACTION_W = 3;
   localparam int KIND_W   = 2;
   localparam int TICKS_W  = 16;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   localparam logic [TICKS_W-1:0] LONG_PRESS_RESET   = 16'd500;
   localparam logic [TICKS_W-1:0] COMMAND_HOLD_RESET = 16'd300;

   typedef enum logic [OP_W-1:0] {
      OP_TICK    = 2'd0,
      OP_PRESS   = 2'd1,
      OP_RELEASE = 2'd2,
      OP_POLL    = 2'd3
   } op_type;

   typedef enum logic [ACTION_W-1:0] {
      ACT_NONE        = 3'd0,
      ACT_BEGIN_PUSH  = 3'd1,
      ACT_BEGIN_PULL  = 3'd2,
      ACT_END_PUSH    = 3'd3,
      ACT_END_PULL    = 3'd4,
      ACT_TOGGLE_PUSH = 3'd5,
      ACT_TOGGLE_PULL = 3'd6
   } action_type;

   // Target kinds held in the configuration registers.
   localparam logic [KIND_W-1:0] TGT_NONE    = 2'd0;
   localparam logic [KIND_W-1:0] TGT_COMMAND = 2'd1;
   localparam logic [KIND_W-1:0] TGT_TOGGLE  = 2'd2;

   // Kind of a command that has been begun and awaits its end.
   typedef enum logic [KIND_W-1:0] {
      CMD_NONE = 2'd0,
      CMD_PUSH = 2'd1,
      CMD_PULL = 2'd2
   } cmd_kind_type;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_LONG_PRESS   = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_COMMAND_HOLD = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_PUSH_TARGET  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_PULL_TARGET  = 2'd3;

   typedef struct packed {
      logic   valid;
      op_type op;
      logic   sublayer_match;
   } item_type;

   typedef struct packed {
      action_type action;
      logic       task_done;
   } result_type;

endpackage

@@ hw/rtl/slpa_in_stage.sv @@
// ----------------------------------------------------------------------------
// slpa_in_stage: input register
// Captures one item per cycle unless stalled; holds it until the core uses it.
// ----------------------------------------------------------------------------
module slpa_in_stage (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   output logic                       req_stall,
   input  logic [slpa_pkg::OP_W-1:0]  req_op,
   input  logic                       req_sublayer_match,
   input  logic                       advance,
   output slpa_pkg::item_type         item
);
   import slpa_pkg::*;

   logic   valid_ff, valid_in;
   op_type op_ff;
   logic   match_ff;
   logic   load;

   assign req_stall = valid_ff && !advance;
   assign load      = req_valid && !req_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (advance) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         op_ff    <= op_type'(req_op);
         match_ff <= req_sublayer_match;
      end
   end

   assign item.valid          = valid_ff;
   assign item.op             = op_ff;
   assign item.sublayer_match = match_ff;

endmodule

@@ hw/rtl/slpa_core.sv @@
// ----------------------------------------------------------------------------
// slpa_core: press classification and action sequencing
// Holds the configuration registers and the press/command state, and works
// out the result of one event item in a single pass.
// ----------------------------------------------------------------------------
module slpa_core #(
   parameter int TIMER_BITS = slpa_pkg::TIMER_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_write_en,
   input  logic [slpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slpa_pkg::CSR_DATA_W-1:0]  csr_wdata,
   input  slpa_pkg::item_type               item,
   input  logic                             fire,
   output slpa_pkg::result_type             result
);
   import slpa_pkg::*;

   localparam int CMP_BITS = (TIMER_BITS > TICKS_W) ? TIMER_BITS : TICKS_W;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic [TICKS_W-1:0] long_press_ff, command_hold_ff;
   logic [KIND_W-1:0]  push_target_ff, pull_target_ff;

   logic                  press_seen_ff, press_seen_in;
   logic                  release_seen_ff, release_seen_in;
   logic [TIMER_BITS-1:0] since_press_ff, since_press_in;
   logic [TIMER_BITS-1:0] held_length_ff, held_length_in;
   logic                  command_started_ff, command_started_in;
   cmd_kind_type          command_kind_ff, command_kind_in;
   logic [TIMER_BITS-1:0] since_command_ff, since_command_in;

   logic [CMP_BITS-1:0] since_press_x, held_length_x, since_command_x;
   logic [CMP_BITS-1:0] long_press_x, command_hold_x;
   logic                is_long;
   logic [KIND_W-1:0]   target;

   assign since_press_x   = CMP_BITS'(since_press_ff);
   assign held_length_x   = CMP_BITS'(held_length_ff);
   assign since_command_x = CMP_BITS'(since_command_ff);
   assign long_press_x    = CMP_BITS'(long_press_ff);
   assign command_hold_x  = CMP_BITS'(command_hold_ff);

   // A missing release counts as a long press.
   assign is_long = !release_seen_ff || (held_length_x > long_press_x);
   assign target  = is_long ? pull_target_ff : push_target_ff;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         long_press_ff   <= LONG_PRESS_RESET;
         command_hold_ff <= COMMAND_HOLD_RESET;
         push_target_ff  <= TGT_NONE;
         pull_target_ff  <= TGT_NONE;
      end else if (csr_write_en) begin
         case (csr_index)
            CSR_LONG_PRESS:   long_press_ff   <= csr_wdata;
            CSR_COMMAND_HOLD: command_hold_ff <= csr_wdata;
            CSR_PUSH_TARGET:  push_target_ff  <= csr_wdata[KIND_W-1:0];
            CSR_PULL_TARGET:  pull_target_ff  <= csr_wdata[KIND_W-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      press_seen_in      = press_seen_ff;
      release_seen_in    = release_seen_ff;
      since_press_in     = since_press_ff;
      held_length_in     = held_length_ff;
      command_started_in = command_started_ff;
      command_kind_in    = command_kind_ff;
      since_command_in   = since_command_ff;
      result.action      = ACT_NONE;
      result.task_done   = 1'b0;

      case (item.op)
         OP_TICK: begin
            if (press_seen_ff && (since_press_ff != TMAX)) begin
               since_press_in = since_press_ff + 1'b1;
            end
            if (command_started_ff && (since_command_ff != TMAX)) begin
               since_command_in = since_command_ff + 1'b1;
            end
         end
         OP_PRESS: begin
            press_seen_in      = 1'b1;
            release_seen_in    = 1'b0;
            since_press_in     = '0;
            held_length_in     = '0;
            command_started_in = 1'b0;
            command_kind_in    = CMD_NONE;
            since_command_in   = '0;
         end
         OP_RELEASE: begin
            if (press_seen_ff) begin
               release_seen_in = 1'b1;
               held_length_in  = since_press_ff;
            end
         end
         OP_POLL: begin
            if (!item.sublayer_match || !press_seen_ff) begin
               press_seen_in      = 1'b0;
               release_seen_in    = 1'b0;
               since_press_in     = '0;
               held_length_in     = '0;
               command_started_in = 1'b0;
               command_kind_in    = CMD_NONE;
               since_command_in   = '0;
               result.task_done   = 1'b1;
            end else if (command_started_ff) begin
               if (since_command_x > command_hold_x) begin
                  case (command_kind_ff)
                     CMD_PUSH: result.action = ACT_END_PUSH;
                     CMD_PULL: result.action = ACT_END_PULL;
                     default:  result.action = ACT_NONE;
                  endcase
                  press_seen_in      = 1'b0;
                  release_seen_in    = 1'b0;
                  since_press_in     = '0;
                  held_length_in     = '0;
                  command_started_in = 1'b0;
                  command_kind_in    = CMD_NONE;
                  since_command_in   = '0;
                  result.task_done   = 1'b1;
               end
            end else if (release_seen_ff || (since_press_x >= long_press_x)) begin
               command_started_in = 1'b1;
               since_command_in   = '0;
               case (target)
                  TGT_TOGGLE: begin
                     result.action    = is_long ? ACT_TOGGLE_PULL : ACT_TOGGLE_PUSH;
                     result.task_done = 1'b1;
                  end
                  TGT_COMMAND: begin
                     command_kind_in = is_long ? CMD_PULL : CMD_PUSH;
                     result.action   = is_long ? ACT_BEGIN_PULL : ACT_BEGIN_PUSH;
                  end
                  default: begin
                     result.task_done = 1'b1;
                  end
               endcase
            end
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         press_seen_ff      <= 1'b0;
         release_seen_ff    <= 1'b0;
         since_press_ff     <= '0;
         held_length_ff     <= '0;
         command_started_ff <= 1'b0;
         command_kind_ff    <= CMD_NONE;
         since_command_ff   <= '0;
      end else if (fire) begin
         press_seen_ff      <= press_seen_in;
         release_seen_ff    <= release_seen_in;
         since_press_ff     <= since_press_in;
         held_length_ff     <= held_length_in;
         command_started_ff <= command_started_in;
         command_kind_ff    <= command_kind_in;
         since_command_ff   <= since_command_in;
      end
   end

   // A pending command kind is only ever held while a command is running.
   a_kind_needs_start: assert property (@(posedge clock) disable iff (reset)
      (command_kind_ff != CMD_NONE) |-> command_started_ff)
      else $error("command kind set without a started command");

   // A release is only recorded after a press.
   a_release_after_press: assert property (@(posedge clock) disable iff (reset)
      release_seen_ff |-> press_seen_ff)
      else $error("release recorded without a press");

   // A press restarts the timing from a clean state.
   a_press_clears: assert property (@(posedge clock) disable iff (reset)
      (fire && (item.op == OP_PRESS)) |=>
         (press_seen_ff && !release_seen_ff && !command_started_ff &&
          (since_press_ff == '0)))
      else $error("press did not restart the timing");

   // Events other than a poll produce an empty result.
   a_non_poll_quiet: assert property (@(posedge clock) disable iff (reset)
      (item.valid && (item.op != OP_POLL)) |->
         ((result.action == ACT_NONE) && !result.task_done))
      else $error("non-poll event produced an action");

   // A toggle always finishes the task.
   a_toggle_done: assert property (@(posedge clock) disable iff (reset)
      (item.valid && ((result.action == ACT_TOGGLE_PUSH) ||
                      (result.action == ACT_TOGGLE_PULL))) |-> result.task_done)
      else $error("toggle without task done");

endmodule

@@ hw/rtl/slpa_out_stage.sv @@
// ----------------------------------------------------------------------------
// slpa_out_stage: result register
// Holds one result item until the receiver takes it.
// ----------------------------------------------------------------------------
module slpa_out_stage (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              load,
   input  slpa_pkg::result_type              result,
   output logic                              ready,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [slpa_pkg::ACTION_W-1:0]     rsp_action,
   output logic                              rsp_task_done
);
   import slpa_pkg::*;

   logic       valid_ff, valid_in;
   result_type result_ff;

   assign ready = !valid_ff || !rsp_stall;

   always_comb begin
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end else begin
         valid_in = valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         result_ff <= result;
      end
   end

   assign rsp_valid     = valid_ff;
   assign rsp_action    = result_ff.action;
   assign rsp_task_done = result_ff.task_done;

endmodule

@@ hw/rtl/short_long_press_action_fsm.sv @@
// ----------------------------------------------------------------------------
// short_long_press_action_fsm: short/long press classifier and action driver
// Top level: input register, classification core and result register.
// ----------------------------------------------------------------------------
// The block takes one event item (tick, press, release or poll) per clock
// cycle and returns exactly one result item for each, in order. An accepted
// item is held in the input register, is evaluated against the press and
// command state by the core, and lands in the result register, from which
// the receiver takes it. Throughput is one item per cycle for as long as
// the receiver does not stall; the single state update in the core sets
// that figure. A stall on the result side holds the result register and,
// once the input register is full as well, raises req_stall.
// Configuration registers are written through the csr_ port and are
// expected to change only while no item is in flight. The press and command
// timers are TIMER_BITS wide and saturate; if they are narrower than a
// programmed threshold, the matching wait never expires.
module short_long_press_action_fsm #(
   parameter int TIMER_BITS = slpa_pkg::TIMER_BITS_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  logic [slpa_pkg::OP_W-1:0]        req_op,
   input  logic                             req_sublayer_match,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output logic [slpa_pkg::ACTION_W-1:0]    rsp_action,
   output logic                             rsp_task_done,
   input  logic                             csr_write_en,
   input  logic [slpa_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [slpa_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import slpa_pkg::*;

   item_type   item;
   result_type result;
   logic       out_ready;
   logic       fire;

   // The item in the input register is evaluated in the cycle in which the
   // result register can take its result; the state moves at that edge too.
   assign fire = item.valid && out_ready;

   slpa_in_stage u_in_stage (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_stall          (req_stall),
      .req_op             (req_op),
      .req_sublayer_match (req_sublayer_match),
      .advance            (fire),
      .item               (item)
   );

   slpa_core #(
      .TIMER_BITS (TIMER_BITS)
   ) u_core (
      .clock        (clock),
      .reset        (reset),
      .csr_write_en (csr_write_en),
      .csr_index    (csr_index),
      .csr_wdata    (csr_wdata),
      .item         (item),
      .fire         (fire),
      .result       (result)
   );

   slpa_out_stage u_out_stage (
      .clock         (clock),
      .reset         (reset),
      .load          (fire),
      .result        (result),
      .ready         (out_ready),
      .rsp_valid     (rsp_valid),
      .rsp_stall     (rsp_stall),
      .rsp_action    (rsp_action),
      .rsp_task_done (rsp_task_done)
   );

endmodule
